FILE: rtl/core/lit_pkg.sv
// ----------------------------------------------------------------------------
// lit_pkg
// Shared types, codes and constants for the looping interval timer.
// ----------------------------------------------------------------------------
package lit_pkg;

   // Field widths
   localparam int unsigned OP_W    = 2;
   localparam int unsigned DELTA_W = 16;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned CSR_W   = 32;
   localparam int unsigned CSR_IDX_W = 1;

   // Timer run state, also the encoding of the timer_state result field
   typedef enum logic [1:0] {
      ST_INITIAL  = 2'd0,
      ST_RUNNING  = 2'd1,
      ST_PAUSED   = 2'd2,
      ST_FINISHED = 2'd3
   } run_state_type;

   // Item opcodes
   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 2'd0,
      OP_RUN     = 2'd1,
      OP_PAUSE   = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERIOD = 1'd0,
      CSR_LIMIT  = 1'd1
   } csr_index_type;

   // Architectural timer state
   typedef struct packed {
      run_state_type        run;
      logic [TIME_W-1:0]    elapsed;
      logic [COUNT_W-1:0]   loops;
   } timer_type;

   // Timer configuration
   typedef struct packed {
      logic [TIME_W-1:0]    period;
      logic [CSR_W-1:0]     limit;   // two's complement, negative = forever
   } timer_cfg_type;

endpackage : lit_pkg

FILE: rtl/core/lit_if.sv
// ----------------------------------------------------------------------------
// lit_req_if / lit_rsp_if
// Valid/ready channels carrying timer items and timer results.
// ----------------------------------------------------------------------------
interface lit_req_if;
   import lit_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [DELTA_W-1:0]  delta_ms;

   modport source (output valid, output op, output delta_ms, input ready);
   modport sink   (input valid, input op, input delta_ms, output ready);
endinterface : lit_req_if

interface lit_rsp_if;
   import lit_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          timer_state;
   logic [TIME_W-1:0]   elapsed_ms;
   logic [COUNT_W-1:0]  loops_done;
   logic                loop_wrapped;

   modport source (output valid, output timer_state, output elapsed_ms,
                   output loops_done, output loop_wrapped, input ready);
   modport sink   (input valid, input timer_state, input elapsed_ms,
                   input loops_done, input loop_wrapped, output ready);
endinterface : lit_rsp_if

FILE: rtl/core/lit_step.sv
// ----------------------------------------------------------------------------
// lit_step
// Next-state logic for one timer item: saturating accumulate, period compare,
// loop count and finish check, plus the run/pause/restart commands.
// ----------------------------------------------------------------------------
module lit_step (
   input  lit_pkg::timer_type           cur,
   input  lit_pkg::timer_cfg_type       cfg,
   input  logic [lit_pkg::OP_W-1:0]     op,
   input  logic [lit_pkg::DELTA_W-1:0]  delta_ms,
   output lit_pkg::timer_type           nxt,
   output logic                         wrapped
);
   import lit_pkg::*;

   logic [TIME_W:0]     sum;
   logic [TIME_W-1:0]   elapsed_sat;
   logic                reached;
   logic [COUNT_W-1:0]  loops_inc;
   logic                forever_mode;
   logic                limit_hit;
   op_type              op_code;

   assign op_code = op_type'(op);

   // Saturating accumulate and period compare
   assign sum          = {1'b0, cur.elapsed} + {{(TIME_W+1-DELTA_W){1'b0}}, delta_ms};
   assign elapsed_sat  = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   assign reached      = (elapsed_sat >= cfg.period);
   assign loops_inc    = (&cur.loops) ? cur.loops : (cur.loops + COUNT_W'(1));
   assign forever_mode = cfg.limit[CSR_W-1];
   assign limit_hit    = (loops_inc >= cfg.limit);

   // Item decode
   always_comb begin
      nxt     = cur;
      wrapped = 1'b0;
      unique case (op_code)
         OP_TICK: begin
            if (cur.run == ST_RUNNING) begin
               nxt.elapsed = elapsed_sat;
               if (reached) begin
                  wrapped   = 1'b1;
                  nxt.loops = loops_inc;
                  if (!forever_mode && limit_hit) begin
                     nxt.elapsed = '0;
                     nxt.run     = ST_FINISHED;
                  end else begin
                     nxt.elapsed = elapsed_sat - cfg.period;
                  end
               end
            end
         end
         OP_RUN: begin
            if (cur.run == ST_INITIAL || cur.run == ST_PAUSED) begin
               nxt.run = ST_RUNNING;
            end
         end
         OP_PAUSE: begin
            if (cur.run == ST_RUNNING) begin
               nxt.run = ST_PAUSED;
            end
         end
         OP_RESTART: begin
            nxt.run     = ST_INITIAL;
            nxt.elapsed = '0;
            nxt.loops   = '0;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule : lit_step

FILE: rtl/core/looping_interval_timer.sv
// ----------------------------------------------------------------------------
// looping_interval_timer
// Periodic interval timer that counts loops up to a configured limit, or forever for a negative limit.
//
//   channel  dir  beat payload                                   handshake
//   req      in   op, delta_ms                                   valid/ready
//   rsp      out  timer_state, elapsed_ms, loops_done,           valid/ready
//                 loop_wrapped
//   csr      in   csr_index, csr_wdata (period, loop limit)      csr_we
//
// One beat per cycle sustained while rsp is ready; an accepted req beat passes from the
// input register through one pass of lit_step into the rsp register.
// Timer state is updated as a beat leaves the input register, so back-to-back
// beats see each other's effects.
// Synchronous active-high reset clears the timer, registers and both stages.
// A stalled rsp holds its beat; the input register keeps taking beats while
// it can drain into the rsp register.
// CSR writes take effect only while the timer is in its initial state.
// ----------------------------------------------------------------------------
module looping_interval_timer (
   input  logic                            clock,
   input  logic                            reset,
   lit_req_if.sink                         req_bus,
   lit_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [lit_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lit_pkg::CSR_W-1:0]       csr_wdata
);
   import lit_pkg::*;

   // Input register
   logic                s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]     s1_op_ff;
   logic [DELTA_W-1:0]  s1_delta_ff;

   // Timer state and configuration
   timer_type           timer_ff, timer_in;
   timer_cfg_type       cfg_ff, cfg_in;

   // Result register
   logic                out_valid_ff, out_valid_in;
   timer_type           out_timer_ff;
   logic                out_wrapped_ff;

   timer_type           step_nxt;
   logic                step_wrapped;
   logic                req_take;
   logic                advance;

   // Handshake
   assign advance     = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_take    = req_bus.valid && req_bus.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);

   // Per-item timer update
   lit_step u_step (
      .cur      (timer_ff),
      .cfg      (cfg_ff),
      .op       (s1_op_ff),
      .delta_ms (s1_delta_ff),
      .nxt      (step_nxt),
      .wrapped  (step_wrapped)
   );

   assign timer_in = advance ? step_nxt : timer_ff;

   // CSR writes, initial state only
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we && timer_ff.run == ST_INITIAL) begin
         unique case (csr_index_type'(csr_index))
            CSR_PERIOD: cfg_in.period = csr_wdata[TIME_W-1:0];
            CSR_LIMIT:  cfg_in.limit  = csr_wdata;
            default:    cfg_in        = cfg_ff;
         endcase
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         timer_ff     <= '{run: ST_INITIAL, elapsed: '0, loops: '0};
         cfg_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         timer_ff     <= timer_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff    <= req_bus.op;
         s1_delta_ff <= req_bus.delta_ms;
      end
      if (advance) begin
         out_timer_ff   <= step_nxt;
         out_wrapped_ff <= step_wrapped;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.timer_state  = out_timer_ff.run;
   assign rsp_bus.elapsed_ms   = out_timer_ff.elapsed;
   assign rsp_bus.loops_done   = out_timer_ff.loops;
   assign rsp_bus.loop_wrapped = out_wrapped_ff;

   // Assertions
   a_wrap_state: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_wrapped_ff) |->
         (out_timer_ff.run == ST_RUNNING || out_timer_ff.run == ST_FINISHED))
      else $error("loop wrap reported outside running or finished");

   a_finish_clear: assert property (@(posedge clock) disable iff (reset)
      (timer_ff.run == ST_FINISHED) |-> (timer_ff.elapsed == '0))
      else $error("finished timer holds elapsed time");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && op_type'(s1_op_ff) == OP_RESTART) |=>
         (timer_ff.run == ST_INITIAL && timer_ff.elapsed == '0 && timer_ff.loops == '0))
      else $error("restart did not clear timer");

   a_cfg_hold: assert property (@(posedge clock) disable iff (reset)
      ($past(timer_ff.run) != ST_INITIAL) |-> $stable(cfg_ff))
      else $error("configuration changed outside initial state");

endmodule : looping_interval_timer

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the looping interval timer. Beats are pushed on the
// req channel with random gaps. A mirror of the timer in this file predicts
// each rsp beat, and a checker compares every field in order of arrival.
// Directed tests cover commands, limits and a period near the top of the
// range. A pressure test holds rsp off until the block stalls. Random sessions
// then follow, each of them restart, configure, run and then mostly ticks.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lit_pkg::*;

   localparam int unsigned RUN_LIMIT    = 1_000_000;
   localparam int unsigned RANDOM_BEATS = 840;
   localparam int unsigned SETTLE       = 8;

   typedef struct packed {
      run_state_type        state;
      logic [TIME_W-1:0]    elapsed;
      logic [COUNT_W-1:0]   loops;
      logic                 wrapped;
   } status_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_W-1:0]       csr_wdata;

   lit_req_if req_bus();
   lit_rsp_if rsp_bus();

   looping_interval_timer dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the timer and its registers
   run_state_type          mirror_state;
   logic [TIME_W-1:0]      mirror_elapsed;
   logic [COUNT_W-1:0]     mirror_loops;
   logic [TIME_W-1:0]      mirror_period;
   logic [CSR_W-1:0]       mirror_limit;

   status_type             expected_status[$];
   int unsigned            error_count;
   int unsigned            hold_request;   // rsp hold-off length, taken by checker
   bit                     steady_flow;    // no gaps on either side

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Steps the mirror by one beat and returns the status it should report
   function automatic status_type advance_timer(op_type op, logic [DELTA_W-1:0] delta);
      logic [TIME_W:0] sum;
      status_type      status;
      status.wrapped = 1'b0;
      case (op)
         OP_TICK: begin
            if (mirror_state == ST_RUNNING) begin
               sum = {1'b0, mirror_elapsed} + delta;
               mirror_elapsed = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
               if (mirror_elapsed >= mirror_period) begin
                  status.wrapped = 1'b1;
                  if (mirror_loops != '1) mirror_loops++;
                  // sign bit set: loop forever
                  if (mirror_limit[CSR_W-1]) begin
                     mirror_elapsed -= mirror_period;
                  end else if (mirror_loops >= mirror_limit) begin
                     mirror_elapsed = '0;
                     mirror_state   = ST_FINISHED;
                  end else begin
                     mirror_elapsed -= mirror_period;
                  end
               end
            end
         end
         OP_RUN: begin
            if (mirror_state == ST_INITIAL || mirror_state == ST_PAUSED)
               mirror_state = ST_RUNNING;
         end
         OP_PAUSE: begin
            if (mirror_state == ST_RUNNING) mirror_state = ST_PAUSED;
         end
         default: begin
            mirror_state   = ST_INITIAL;
            mirror_elapsed = '0;
            mirror_loops   = '0;
         end
      endcase
      status.state   = mirror_state;
      status.elapsed = mirror_elapsed;
      status.loops   = mirror_loops;
      return status;
   endfunction

   // Gap length: mostly none or short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (steady_flow) return 0;
      roll = $urandom_range(0, 19);
      if (roll < 11) return 0;
      if (roll < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // Offers one beat and waits for it to be taken; valid stays up afterwards
   task automatic send_beat(op_type op, logic [DELTA_W-1:0] delta);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.op       <= op;
      req_bus.delta_ms <= delta;
      do @(posedge clock); while (!req_bus.ready);
      expected_status.push_back(advance_timer(op, delta));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
   endtask

   // Register write once the block is idle; ignored outside the initial state
   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (mirror_state == ST_INITIAL) begin
         case (idx)
            CSR_PERIOD: mirror_period = value;
            CSR_LIMIT:  mirror_limit  = value;
            default: ;
         endcase
      end
      @(posedge clock);
   endtask

   // Result checker and rsp ready pattern
   initial begin : result_check
      status_type  want;
      int unsigned stall_left;
      rsp_bus.ready = 1'b0;
      stall_left    = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_status.size() == 0) begin
               report_mismatch("beat with nothing expected", rsp_bus.loops_done, '0);
            end else begin
               want = expected_status.pop_front();
               if (rsp_bus.timer_state !== want.state)
                  report_mismatch("timer_state", 32'(rsp_bus.timer_state),
                                  32'(want.state));
               if (rsp_bus.elapsed_ms !== want.elapsed)
                  report_mismatch("elapsed_ms", rsp_bus.elapsed_ms, want.elapsed);
               if (rsp_bus.loops_done !== want.loops)
                  report_mismatch("loops_done", rsp_bus.loops_done, want.loops);
               if (rsp_bus.loop_wrapped !== want.wrapped)
                  report_mismatch("loop_wrapped", 32'(rsp_bus.loop_wrapped),
                                  32'(want.wrapped));
            end
         end
         // a requested hold-off overrides any stall in progress
         if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
         end
      end
   end

   // Commands in every state, pause and resume, exact period, loop limit
   task automatic test_commands();
      write_reg(CSR_PERIOD, 32'd10);
      write_reg(CSR_LIMIT, 32'd2);
      send_beat(OP_TICK, 16'd5);         // not running: ignored
      send_beat(OP_PAUSE, 16'd0);        // no effect from initial
      send_beat(OP_RUN, 16'd0);
      send_beat(OP_RUN, 16'd0);          // already running
      send_beat(OP_TICK, 16'd3);
      send_beat(OP_PAUSE, 16'd0);
      send_beat(OP_TICK, 16'd9);         // paused: ignored
      write_reg(CSR_PERIOD, 32'd1000);   // not initial: dropped
      send_beat(OP_RUN, 16'd0);          // resume
      send_beat(OP_TICK, 16'd7);         // lands exactly on the period
      send_beat(OP_TICK, 16'hFFFF);      // second loop hits the limit
      send_beat(OP_TICK, 16'd4);         // finished: ignored
      send_beat(OP_RUN, 16'd0);
      send_beat(OP_PAUSE, 16'd0);
      send_beat(OP_RESTART, 16'hFFFF);
   endtask

   // Zero period, zero limit, most negative limit, largest limit and period
   task automatic test_limits();
      write_reg(CSR_PERIOD, '0);
      write_reg(CSR_LIMIT, '0);
      send_beat(OP_RUN, 16'd0);
      send_beat(OP_TICK, 16'd5);         // first loop finishes
      send_beat(OP_RESTART, 16'd0);
      write_reg(CSR_LIMIT, 32'h8000_0000);
      send_beat(OP_RUN, 16'd0);
      send_beat(OP_TICK, 16'hFFFF);
      send_beat(OP_TICK, 16'd0);         // zero period still wraps
      send_beat(OP_RESTART, 16'd0);
      write_reg(CSR_PERIOD, '1);
      write_reg(CSR_LIMIT, 32'h7FFF_FFFF);
      send_beat(OP_RUN, 16'd0);
      send_beat(OP_TICK, 16'hFFFF);
      send_beat(OP_RESTART, 16'd0);
   endtask

   // Largest period: full-scale ticks back to back keep accumulating, no wrap
   task automatic test_elapsed_saturation();
      write_reg(CSR_PERIOD, '1);
      write_reg(CSR_LIMIT, '1);
      steady_flow = 1'b1;
      send_beat(OP_RUN, 16'd0);
      send_beat(OP_TICK, 16'd1);
      repeat (40) send_beat(OP_TICK, 16'hFFFF);
      send_beat(OP_RESTART, 16'd0);
      wait_drained();
      steady_flow = 1'b0;
   endtask

   // Hold rsp off while beats keep coming, so the block backs up
   task automatic test_output_stall();
      write_reg(CSR_PERIOD, 32'd100);
      write_reg(CSR_LIMIT, '1);
      send_beat(OP_RUN, 16'd0);
      wait_drained();
      steady_flow  = 1'b1;
      hold_request = 80;
      for (int i = 0; i < 12; i++) send_beat(OP_TICK, 16'(i * 17));
      send_beat(OP_RESTART, 16'd0);
      wait_drained();
      steady_flow = 1'b0;
   endtask

   // Random sessions: restart, configure, run, then mostly ticks
   task automatic test_random_sessions();
      int unsigned        counted;
      int unsigned        roll;
      logic [TIME_W-1:0]  period;
      logic [CSR_W-1:0]   limit;
      logic [DELTA_W-1:0] delta;
      counted = 0;
      while (counted < RANDOM_BEATS) begin
         steady_flow = ($urandom_range(0, 4) == 0);
         send_beat(OP_RESTART, 16'($urandom_range(0, 65535)));
         counted++;
         case ($urandom_range(0, 9))
            0:       period = '0;
            1:       period = '1;
            2:       period = $urandom;
            3:       period = $urandom_range(40000, 200000);
            default: period = $urandom_range(1, 300);
         endcase
         case ($urandom_range(0, 9))
            0:       limit = '1;
            1:       limit = '0;
            2:       limit = 32'h7FFF_FFFF;
            3:       limit = 32'h8000_0000 | $urandom;
            4:       limit = $urandom;
            default: limit = $urandom_range(1, 6);
         endcase
         write_reg(CSR_PERIOD, period);
         write_reg(CSR_LIMIT, limit);
         send_beat(OP_RUN, 16'($urandom_range(0, 65535)));
         counted++;
         repeat ($urandom_range(8, 40)) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
               case ($urandom_range(0, 7))
                  0: delta = 16'($urandom_range(0, 65535));
                  1: delta = '0;
                  2: delta = '1;
                  default: begin
                     if (mirror_period < 40000)
                        delta = 16'($urandom_range(0, mirror_period * 3 / 2 + 1));
                     else
                        delta = 16'($urandom_range(0, 65535));
                  end
               endcase
               counted++;
               send_beat(OP_TICK, delta);
            end else if (roll < 88) begin
               counted++;
               send_beat(OP_PAUSE, 16'($urandom_range(0, 65535)));
            end else if (roll < 96) begin
               counted++;
               send_beat(OP_RUN, 16'($urandom_range(0, 65535)));
            end else if (roll < 98) begin
               counted++;
               send_beat(OP_RESTART, 16'($urandom_range(0, 65535)));
            end else begin
               // takes effect only if a restart left the timer initial
               write_reg(csr_index_type'($urandom_range(0, 1)), $urandom);
            end
         end
      end
      wait_drained();
      steady_flow = 1'b0;
   endtask

   // Main sequence
   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_PERIOD;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.op       = OP_TICK;
      req_bus.delta_ms = '0;
      mirror_state     = ST_INITIAL;
      mirror_elapsed   = '0;
      mirror_loops     = '0;
      mirror_period    = '0;
      mirror_limit     = '0;
      error_count      = 0;
      hold_request     = 0;
      steady_flow      = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_commands();
      test_limits();
      test_elapsed_saturation();
      test_output_stall();
      test_random_sessions();

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && expected_status.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule : testbench

FILE: sim.f
rtl/core/lit_pkg.sv
rtl/core/lit_if.sv
rtl/core/lit_step.sv
rtl/core/looping_interval_timer.sv
tb/testbench.sv
